@@ sv/lsfl_pkg.sv @@
// Shared types and constants for the LED driver set-frame link.
// Holds the frame byte values, action/status/register codes and the result descriptor.
// No dependencies.
package lsfl_pkg;

  // Frame bytes
  localparam logic [7:0] HDR_BYTE  = 8'h3A;
  localparam logic [7:0] CMD_BYTE  = 8'h3C;
  localparam logic [7:0] OFS_BYTE  = 8'hEE;
  localparam logic [7:0] LEN_BYTE  = 8'h05;
  localparam logic [7:0] MASK_BYTE = 8'h0F;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] LEVEL_MAX = 8'd200;

  // Fixed part of the checksum: low byte of 3C + EE + 05 + 0F
  localparam logic [7:0] CHK_BASE = 8'(9'(CMD_BYTE) + 9'(OFS_BYTE) + 9'(LEN_BYTE)
                                       + 9'(MASK_BYTE));

  // Frame length and beat counter
  localparam int FRAME_LEN = 12;
  localparam int BEAT_W    = $clog2(FRAME_LEN);
  localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(FRAME_LEN - 1);

  // Reply gathering: eight bytes, positions of the checked bytes
  localparam int RX_W = 3;
  localparam logic [RX_W-1:0] RX_POS_HDR   = 3'd0;
  localparam logic [RX_W-1:0] RX_POS_REPLY = 3'd1;
  localparam logic [RX_W-1:0] RX_POS_ACK   = 3'd4;
  localparam logic [RX_W-1:0] RX_POS_LAST  = 3'd7;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RX   = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_REPLY_CODE    = 2'd0,
    REG_ACK_CODE      = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } reg_index_t;

  // One pending result: a whole frame or a single status
  typedef struct packed {
    logic       is_frame;
    logic [7:0] red;
    logic [7:0] blue;
    logic [7:0] far_red;
    logic [7:0] white;
    logic [7:0] chk;
    status_t    status;
  } desc_t;

  function automatic logic [7:0] clamp_level(input logic [7:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

@@ sv/led_driver_set_frame_link_unit.sv @@
// Host side of a four-channel LED driver link.
// Input items (s_*): s_tuser carries the action: send set command, received byte or
// millisecond tick. s_tdata carries the four channel levels and the received byte.
// Output items (m_*): m_tuser is 0 for a frame byte and 1 for a reply status;
// m_tdata holds the byte and the status code; m_tlast marks the frame end and every status.
// A send gives a twelve-byte frame (3A 3C EE 05 0F, red, blue, far red, white,
// checksum, 0D 0A) with levels clamped to 200. The block then gathers an eight-byte
// reply starting at header 3A and reports ok or fail, or reports timeout once the counted
// ticks reach timeout_ticks; a zero setting expires on the first tick.
// The item is registered in lsfl_ctrl and its result is registered again in the
// frame sender before it shows on m_*; a busy sender can hold it back.
// The sender gives one output item per cycle while m_tready is high; a send occupies
// it for twelve frame bytes, a status for one item. Items that give no result skip it.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while the block is
// idle (left to the user, unchecked): 0 reply code, 1 acknowledge code, 2 timeout ticks.
// Reset clears the link state and the configuration to its defaults.
// When the receiver stalls, the current item holds on m_*, and input stalls once
// the item register holds an item with a result and the sender still holds work.
// Depends on lsfl_pkg, lsfl_ctrl and lsfl_frame_tx.
module led_driver_set_frame_link_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // red_level, far_red_level, blue_level, white_level, rx_data
  input  logic [1:0]  s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // tx_data, status, zero fill
  output logic        m_tuser,  // kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lsfl_pkg::*;

  logic  desc_valid;
  logic  desc_ready;
  desc_t desc;

  lsfl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  lsfl_frame_tx u_frame_tx (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

@@ sv/lsfl_ctrl.sv @@
// Link control: input item register, configuration registers, reply/timeout state.
// Turns each item into at most one result descriptor for the frame sender.
// Depends on lsfl_pkg.
module lsfl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [39:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               desc_valid,
  input  logic               desc_ready,
  output lsfl_pkg::desc_t    desc
);
  import lsfl_pkg::*;

  // Input register
  logic        in_valid;
  action_t     in_action;
  logic [7:0]  in_red, in_far_red, in_blue, in_white, in_rx;

  // Configuration
  logic [7:0]  reply_code, ack_code;
  logic [15:0] timeout_ticks;

  // Link state
  logic            waiting, waiting_next;
  logic [RX_W-1:0] rx_count, rx_count_next;
  logic [15:0]     elapsed, elapsed_next;
  logic [7:0]      seen_reply_code, seen_reply_code_next;
  logic [7:0]      seen_ack, seen_ack_next;

  logic       has_result;
  logic       consume;
  logic [7:0] c_red, c_far_red, c_blue, c_white;
  logic [15:0] elapsed_inc;

  // Hold the item until the sender can take its result
  assign consume  = in_valid && (!has_result || desc_ready);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_action  <= action_t'(s_tuser);
      in_red     <= s_tdata[7:0];
      in_far_red <= s_tdata[15:8];
      in_blue    <= s_tdata[23:16];
      in_white   <= s_tdata[31:24];
      in_rx      <= s_tdata[39:32];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_code    <= '0;
      ack_code      <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPLY_CODE:    reply_code    <= cfg_data[7:0];
        REG_ACK_CODE:      ack_code      <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp levels for the frame and checksum; saturating step of the elapsed tick count
  assign c_red     = clamp_level(in_red);
  assign c_far_red = clamp_level(in_far_red);
  assign c_blue    = clamp_level(in_blue);
  assign c_white   = clamp_level(in_white);
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 16'd1;

  // Next link state and the result, if any
  always_comb begin
    waiting_next         = waiting;
    rx_count_next        = rx_count;
    elapsed_next         = elapsed;
    seen_reply_code_next = seen_reply_code;
    seen_ack_next        = seen_ack;
    has_result           = 1'b0;
    desc.is_frame        = 1'b0;
    desc.red             = c_red;
    desc.blue            = c_blue;
    desc.far_red         = c_far_red;
    desc.white           = c_white;
    desc.chk             = CHK_BASE + c_red + c_blue + c_far_red + c_white;
    desc.status          = ST_OK;
    unique case (in_action)
      ACT_SEND: begin
        waiting_next  = 1'b1;
        rx_count_next = '0;
        elapsed_next  = '0;
        has_result    = 1'b1;
        desc.is_frame = 1'b1;
      end
      ACT_RX: begin
        if (waiting && !(rx_count == RX_POS_HDR && in_rx != HDR_BYTE)) begin
          if (rx_count == RX_POS_REPLY) seen_reply_code_next = in_rx;
          if (rx_count == RX_POS_ACK)   seen_ack_next = in_rx;
          rx_count_next = rx_count + 1'b1;
          if (rx_count == RX_POS_LAST) begin
            has_result    = 1'b1;
            waiting_next  = 1'b0;
            rx_count_next = '0;
            desc.status   = (seen_reply_code == reply_code && seen_ack == ack_code)
                            ? ST_OK : ST_FAIL;
          end
        end
      end
      ACT_TICK: begin
        if (waiting) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= timeout_ticks) begin
            has_result    = 1'b1;
            waiting_next  = 1'b0;
            rx_count_next = '0;
            desc.status   = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  assign desc_valid = in_valid && has_result;

  // Advance link state when the item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting         <= 1'b0;
      rx_count        <= '0;
      elapsed         <= '0;
      seen_reply_code <= '0;
      seen_ack        <= '0;
    end else if (consume) begin
      waiting         <= waiting_next;
      rx_count        <= rx_count_next;
      elapsed         <= elapsed_next;
      seen_reply_code <= seen_reply_code_next;
      seen_ack        <= seen_ack_next;
    end
  end

endmodule

@@ sv/lsfl_frame_tx.sv @@
// Frame sender: holds one result descriptor and plays it out beat by beat.
// A frame gives twelve byte items, a status gives one item.
// Depends on lsfl_pkg.
module lsfl_frame_tx (
  input  logic             clk,
  input  logic             rst,
  input  logic             desc_valid,
  output logic             desc_ready,
  input  lsfl_pkg::desc_t  desc,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);
  import lsfl_pkg::*;

  logic              busy;
  desc_t             cur;
  logic [BEAT_W-1:0] beat;
  logic              is_last;
  logic [7:0]        tx_byte;

  assign is_last    = !cur.is_frame || beat == BEAT_LAST;
  assign desc_ready = !busy || (m_tready && is_last);

  // Load a new descriptor or step through the current frame
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (desc_ready) begin
      busy <= desc_valid;
      beat <= '0;
    end else if (m_tready) begin
      beat <= beat + 1'b1;
    end
    if (desc_ready && desc_valid) begin
      cur <= desc;
    end
  end

  // Pick the frame byte for this beat
  always_comb begin
    case (beat)
      4'd0:    tx_byte = HDR_BYTE;
      4'd1:    tx_byte = CMD_BYTE;
      4'd2:    tx_byte = OFS_BYTE;
      4'd3:    tx_byte = LEN_BYTE;
      4'd4:    tx_byte = MASK_BYTE;
      4'd5:    tx_byte = cur.red;
      4'd6:    tx_byte = cur.blue;
      4'd7:    tx_byte = cur.far_red;
      4'd8:    tx_byte = cur.white;
      4'd9:    tx_byte = cur.chk;
      4'd10:   tx_byte = CR_BYTE;
      4'd11:   tx_byte = LF_BYTE;
      default: tx_byte = '0;
    endcase
  end

  assign m_tvalid = busy;
  assign m_tuser  = !cur.is_frame;
  assign m_tlast  = is_last;
  assign m_tdata  = cur.is_frame ? {8'd0, tx_byte} : {6'd0, cur.status, 8'd0};

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the LED driver set-frame link unit.
// Drives set commands, reply bytes and ticks through the stream ports and
// compares every output item with a predicted frame byte or reply status.
// Depends on lsfl_pkg and led_driver_set_frame_link_unit.
`timescale 1ns / 1ps

module tb_top;
  import lsfl_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASE_ITEMS   = 42;

  // One output item as seen on the master side
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } link_out_t;

  // Predicts the link and holds the output items still owed by the block
  class link_scoreboard;
    logic [7:0]  reply_code;
    logic [7:0]  ack_code;
    logic [15:0] timeout_ticks;
    bit          waiting;
    int unsigned rx_count;
    logic [15:0] elapsed;
    logic [7:0]  seen_reply;
    logic [7:0]  seen_ack;
    link_out_t   owed_q[$];
    int unsigned errors;
    int unsigned frame_bytes;
    int unsigned status_seen[3];

    function void restart();
      reply_code    = 8'h00;
      ack_code      = 8'h00;
      timeout_ticks = TIMEOUT_RESET;
      waiting       = 1'b0;
      rx_count      = 0;
      elapsed       = 16'h0000;
      seen_reply    = 8'h00;
      seen_ack      = 8'h00;
      owed_q.delete();
      errors        = 0;
      frame_bytes   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] value);
      case (idx)
        REG_REPLY_CODE:    reply_code = value[7:0];
        REG_ACK_CODE:      ack_code = value[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] limit_level(logic [7:0] v);
      return (v > 8'd200) ? 8'd200 : v;
    endfunction

    function void owe(logic kind, logic [7:0] data, logic last, logic [1:0] status);
      link_out_t o;
      o.kind   = kind;
      o.data   = data;
      o.last   = last;
      o.status = status;
      owed_q.push_back(o);
    endfunction

    // Note an accepted input item; returns 1 when the item had any effect
    function bit note_item(action_t act, logic [39:0] dat);
      logic [7:0] frame [12];
      logic [7:0] r, fr, b, w, rx;
      r  = limit_level(dat[7:0]);
      fr = limit_level(dat[15:8]);
      b  = limit_level(dat[23:16]);
      w  = limit_level(dat[31:24]);
      rx = dat[39:32];
      case (act)
        ACT_SEND: begin
          frame[0]  = HDR_BYTE;
          frame[1]  = CMD_BYTE;
          frame[2]  = OFS_BYTE;
          frame[3]  = LEN_BYTE;
          frame[4]  = MASK_BYTE;
          frame[5]  = r;
          frame[6]  = b;
          frame[7]  = fr;
          frame[8]  = w;
          frame[9]  = CMD_BYTE + OFS_BYTE + LEN_BYTE + MASK_BYTE + r + b + fr + w;
          frame[10] = CR_BYTE;
          frame[11] = LF_BYTE;
          for (int i = 0; i < 12; i++) owe(1'b0, frame[i], i == 11, ST_OK);
          waiting  = 1'b1;
          rx_count = 0;
          elapsed  = 16'h0000;
          return 1'b1;
        end
        ACT_RX: begin
          if (!waiting) return 1'b0;
          // drop anything ahead of the header
          if (rx_count == 0 && rx != HDR_BYTE) return 1'b0;
          if (rx_count == 1) seen_reply = rx;
          if (rx_count == 4) seen_ack = rx;
          rx_count++;
          if (rx_count >= 8) begin
            owe(1'b1, 8'h00, 1'b1,
                (seen_reply == reply_code && seen_ack == ack_code) ? ST_OK : ST_FAIL);
            waiting  = 1'b0;
            rx_count = 0;
          end
          return 1'b1;
        end
        ACT_TICK: begin
          if (!waiting) return 1'b0;
          if (elapsed != ELAPSED_MAX) elapsed++;
          if (elapsed >= timeout_ticks) begin
            owe(1'b1, 8'h00, 1'b1, ST_TIMEOUT);
            waiting  = 1'b0;
            rx_count = 0;
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Compare one accepted output item with the oldest owed item
    function void check_result(link_out_t got);
      link_out_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected output item kind %0b data %02h last %0b status %0d",
                 $time, got.kind, got.data, got.last, got.status);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind expected %0b actual %0b", $time, want.kind, got.kind);
        errors++;
      end
      if (got.data !== want.data) begin
        $display("%0t: tx_data expected %02h actual %02h", $time, want.data, got.data);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (want.kind) status_seen[want.status]++;
      else frame_bytes++;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = ACT_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_REPLY_CODE;
  logic [15:0] cfg_data = '0;

  link_scoreboard board;
  int unsigned    cycle_count = 0;
  int unsigned    useful_items = 0;
  int unsigned    settings_used = 0;
  int             send_burst = 0;

  led_driver_set_frame_link_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Level with weight on the clamp edges
  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1:    return 8'd0;
      2, 3:    return 8'd255;
      4:       return 8'd200;
      5:       return 8'd201;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Any byte but the reply header
  function automatic logic [7:0] noise_byte();
    logic [7:0] d;
    d = 8'($urandom_range(0, 255));
    return (d == HDR_BYTE) ? 8'h00 : d;
  endfunction

  // Receiver: random stalls, with occasional long stretches of steady ready
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Check every accepted output item
  always @(posedge clk) begin
    link_out_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind   = m_tuser;
      got.data   = m_tdata[7:0];
      got.last   = m_tlast;
      got.status = m_tdata[9:8];
      board.check_result(got);
    end
  end

  // Offer one input item after a random gap and hold it until accepted
  task automatic push_item(input action_t act, input logic [39:0] dat);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(30, 60);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= dat;
    do @(posedge clk); while (!s_tready);
    if (board.note_item(act, dat)) useful_items++;
  endtask

  task automatic push_send(input logic [7:0] r, input logic [7:0] fr,
                           input logic [7:0] b, input logic [7:0] w);
    push_item(ACT_SEND, {8'($urandom_range(0, 255)), w, b, fr, r});
  endtask

  task automatic push_rx(input logic [7:0] d);
    push_item(ACT_RX, {d, 32'($urandom)});
  endtask

  task automatic push_tick();
    push_item(ACT_TICK, {8'($urandom_range(0, 255)), 32'($urandom)});
  endtask

  // Eight-byte reply with the given code and acknowledge, optionally with ticks mixed in
  task automatic push_reply(input logic [7:0] code, input logic [7:0] ack,
                            input bit with_ticks);
    logic [7:0] d;
    for (int i = 0; i < 8; i++) begin
      d = (i == 0) ? HDR_BYTE : (i == 1) ? code : (i == 4) ? ack
          : 8'($urandom_range(0, 255));
      if (with_ticks && $urandom_range(0, 9) == 0) push_tick();
      push_rx(d);
    end
  endtask

  // Drop valid, wait for all owed items, then let any silent work finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges while the block is idle
  task automatic load_config(input logic [7:0] code, input logic [7:0] ack,
                             input logic [15:0] ticks);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_REPLY_CODE;
    cfg_data  <= {8'h00, code};
    @(posedge clk);
    board.set_reg(REG_REPLY_CODE, {8'h00, code});
    cfg_index <= REG_ACK_CODE;
    cfg_data  <= {8'h00, ack};
    @(posedge clk);
    board.set_reg(REG_ACK_CODE, {8'h00, ack});
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    board.set_reg(REG_TIMEOUT_TICKS, ticks);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random phase: mostly send-and-reply exchanges, some timeouts, restarts and noise
  task automatic run_random(input int budget);
    int unsigned start;
    int pick;
    int n;
    logic [7:0] code, ack;
    start = useful_items;
    while (useful_items - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_send(pick_level(), pick_level(), pick_level(), pick_level());
        repeat ($urandom_range(0, 2)) push_rx(noise_byte());
        code = ($urandom_range(0, 4) != 0) ? board.reply_code : 8'($urandom_range(0, 255));
        ack  = ($urandom_range(0, 4) != 0) ? board.ack_code : 8'($urandom_range(0, 255));
        push_reply(code, ack, 1'b1);
      end else if (pick < 60) begin
        push_send(pick_level(), pick_level(), pick_level(), pick_level());
        if (board.timeout_ticks <= 150) n = board.timeout_ticks + 1;
        else n = $urandom_range(1, 5);
        repeat (n) push_tick();
      end else if (pick < 72) begin
        // restart the wait in the middle of a reply
        push_send(pick_level(), pick_level(), pick_level(), pick_level());
        push_rx(HDR_BYTE);
        repeat ($urandom_range(0, 5)) push_rx(8'($urandom_range(0, 255)));
        push_send(pick_level(), pick_level(), pick_level(), pick_level());
        push_reply(board.reply_code, board.ack_code, 1'b0);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 4))
          push_item(action_t'($urandom_range(0, 3)),
                    {8'($urandom_range(0, 255)), 32'($urandom)});
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) != 0) push_rx(8'($urandom_range(0, 255)));
          else push_tick();
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    board = new();
    board.restart();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: ignored items, clamp extremes and a good reply
    push_item(ACT_NONE, {8'hFF, 32'hFFFF_FFFF});
    push_rx(HDR_BYTE);
    push_tick();
    push_send(8'd255, 8'd255, 8'd255, 8'd255);
    push_rx(8'h55);
    push_reply(8'h00, 8'h00, 1'b0);

    // Short timeout: restart during a wait, then time out
    load_config(8'h5A, 8'hA5, 16'd2);
    push_send(8'd0, 8'd0, 8'd0, 8'd0);
    push_tick();
    push_send(8'd200, 8'd201, 8'd199, 8'd128);
    push_rx(HDR_BYTE);
    push_rx(8'h5A);
    push_tick();
    push_tick();

    // Zero timeout expires on the first tick
    load_config(8'h00, 8'hFF, 16'd0);
    push_send(8'd1, 8'd2, 8'd3, 8'd4);
    push_tick();

    load_config(8'h00, 8'h00, TIMEOUT_RESET);
    run_random(PHASE_ITEMS);
    load_config(8'hFF, 8'hFF, 16'd1);
    run_random(PHASE_ITEMS);
    load_config(8'h5A, 8'hA5, 16'd4);
    run_random(PHASE_ITEMS);
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'hFFFF);
    run_random(PHASE_ITEMS);
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(2, 40)));
    run_random(PHASE_ITEMS);
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(1, 65535)));
    run_random(PHASE_ITEMS);

    drain();
    $display("Run covered %0d effective input items over %0d register settings",
             useful_items, settings_used);
    $display("Checked %0d frame bytes and %0d ok, %0d fail, %0d timeout replies",
             board.frame_bytes, board.status_seen[ST_OK], board.status_seen[ST_FAIL],
             board.status_seen[ST_TIMEOUT]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d output items never arrived",
               board.errors, board.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lsfl_pkg.sv
sv/lsfl_ctrl.sv
sv/lsfl_frame_tx.sv
sv/led_driver_set_frame_link_unit.sv
verif/tb_top.sv
